>>> hdl/mck_pkg.sv
// Shared types, constants, symbol table and microcode for the Morse keyer.
package mck_pkg;

   // Field widths
   localparam int CharWidth  = 8;
   localparam int UnitsWidth = 3;
   localparam int StepWidth  = 3;
   localparam int ElemWidth  = 2;
   localparam int MaxElems   = 5;
   localparam int ElemsWidth = ElemWidth * MaxElems;
   localparam int SymCount   = 36;
   localparam int SymWidth   = 6;

   // Element codes; the code value is also the on time in units
   localparam logic [ElemWidth-1:0] EL_NONE = 2'd0;
   localparam logic [ElemWidth-1:0] EL_DOT  = 2'd1;
   localparam logic [ElemWidth-1:0] EL_DASH = 2'd3;

   // Segment lengths
   localparam logic [UnitsWidth-1:0] WORD_GAP_UNITS   = 3'd7;
   localparam logic [UnitsWidth-1:0] LETTER_GAP_UNITS = 3'd3;
   localparam logic [UnitsWidth-1:0] ELEM_GAP_UNITS   = 3'd1;

   // Characters of interest
   localparam logic [CharWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CharWidth-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;
   localparam logic [SymWidth-1:0]  SYM_X      = 6'd23;
   localparam logic [SymWidth-1:0]  SYM_DIGIT0 = 6'd26;

   // Microcode field codes
   localparam logic [1:0] EMIT_NONE   = 2'd0;
   localparam logic [1:0] EMIT_ALWAYS = 2'd1;
   localparam logic [1:0] EMIT_IF_GAP = 2'd2;

   localparam logic [1:0] UNITS_WORD   = 2'd0;
   localparam logic [1:0] UNITS_LETTER = 2'd1;
   localparam logic [1:0] UNITS_ELEM   = 2'd2;
   localparam logic [1:0] UNITS_ONE    = 2'd3;

   localparam logic [1:0] LAST_NO      = 2'd0;
   localparam logic [1:0] LAST_YES     = 2'd1;
   localparam logic [1:0] LAST_NO_MORE = 2'd2;

   localparam logic [1:0] GAP_HOLD     = 2'd0;
   localparam logic [1:0] GAP_CLEAR    = 2'd1;
   localparam logic [1:0] GAP_FROM_EOM = 2'd2;

   localparam logic [1:0] COND_ALWAYS   = 2'd0;
   localparam logic [1:0] COND_IF_VALID = 2'd1;
   localparam logic [1:0] COND_IF_SPACE = 2'd2;
   localparam logic [1:0] COND_IF_MORE  = 2'd3;

   // Program steps
   localparam logic [StepWidth-1:0] STEP_WAIT     = 3'd0;
   localparam logic [StepWidth-1:0] STEP_DISPATCH = 3'd1;
   localparam logic [StepWidth-1:0] STEP_SPACE    = 3'd2;
   localparam logic [StepWidth-1:0] STEP_LGAP     = 3'd3;
   localparam logic [StepWidth-1:0] STEP_ELEM_ON  = 3'd4;
   localparam logic [StepWidth-1:0] STEP_ELEM_OFF = 3'd5;
   localparam logic [StepWidth-1:0] STEP_FINISH   = 3'd6;
   localparam logic [StepWidth-1:0] STEP_SPARE    = 3'd7;

   // One control word
   typedef struct packed {
      logic [1:0]           emit_sel;
      logic                 key_on;
      logic [1:0]           units_sel;
      logic [1:0]           last_sel;
      logic [1:0]           gap_op;
      logic                 elem_adv;
      logic [1:0]           cond;
      logic [StepWidth-1:0] target;
      logic [StepWidth-1:0] next;
   } ucode_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic is_space;
      logic more;
      logic gap;
      logic out_free;
   } flags_type;

   // Sequencer control to the datapath
   typedef struct packed {
      logic      load;
      logic      emit;
      logic      go;
      ucode_type word;
   } ctrl_type;

   // Program: taken jump goes to target, otherwise to next
   localparam ucode_type UCODE_ROM [0:7] = '{
      // WAIT: hold until a transaction arrives
      '{EMIT_NONE, 1'b0, UNITS_ONE, LAST_NO, GAP_HOLD, 1'b0,
        COND_IF_VALID, STEP_DISPATCH, STEP_WAIT},
      // DISPATCH: space or keyed symbol
      '{EMIT_NONE, 1'b0, UNITS_ONE, LAST_NO, GAP_HOLD, 1'b0,
        COND_IF_SPACE, STEP_SPACE, STEP_LGAP},
      // SPACE: word gap if one is pending
      '{EMIT_IF_GAP, 1'b0, UNITS_WORD, LAST_YES, GAP_CLEAR, 1'b0,
        COND_ALWAYS, STEP_WAIT, STEP_WAIT},
      // LGAP: letter gap if one is pending
      '{EMIT_IF_GAP, 1'b0, UNITS_LETTER, LAST_NO, GAP_HOLD, 1'b0,
        COND_ALWAYS, STEP_ELEM_ON, STEP_ELEM_ON},
      // ELEM_ON: key the current element
      '{EMIT_ALWAYS, 1'b1, UNITS_ELEM, LAST_NO, GAP_HOLD, 1'b0,
        COND_ALWAYS, STEP_ELEM_OFF, STEP_ELEM_OFF},
      // ELEM_OFF: element space, loop while elements remain
      '{EMIT_ALWAYS, 1'b0, UNITS_ONE, LAST_NO_MORE, GAP_HOLD, 1'b1,
        COND_IF_MORE, STEP_ELEM_ON, STEP_FINISH},
      // FINISH: leave a gap pending unless the message ended
      '{EMIT_NONE, 1'b0, UNITS_ONE, LAST_NO, GAP_FROM_EOM, 1'b0,
        COND_ALWAYS, STEP_WAIT, STEP_WAIT},
      // spare
      '{EMIT_NONE, 1'b0, UNITS_ONE, LAST_NO, GAP_HOLD, 1'b0,
        COND_ALWAYS, STEP_WAIT, STEP_WAIT}
   };

   // ITU table, element 0 in the low bits
   localparam logic [ElemsWidth-1:0] MORSE_TAB [0:SymCount-1] = '{
      {EL_NONE, EL_NONE, EL_NONE, EL_DASH, EL_DOT },  // A
      {EL_NONE, EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH},  // B
      {EL_NONE, EL_DOT,  EL_DASH, EL_DOT,  EL_DASH},  // C
      {EL_NONE, EL_NONE, EL_DOT,  EL_DOT,  EL_DASH},  // D
      {EL_NONE, EL_NONE, EL_NONE, EL_NONE, EL_DOT },  // E
      {EL_NONE, EL_DOT,  EL_DASH, EL_DOT,  EL_DOT },  // F
      {EL_NONE, EL_NONE, EL_DOT,  EL_DASH, EL_DASH},  // G
      {EL_NONE, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT },  // H
      {EL_NONE, EL_NONE, EL_NONE, EL_DOT,  EL_DOT },  // I
      {EL_NONE, EL_DASH, EL_DASH, EL_DASH, EL_DOT },  // J
      {EL_NONE, EL_NONE, EL_DASH, EL_DOT,  EL_DASH},  // K
      {EL_NONE, EL_DOT,  EL_DOT,  EL_DASH, EL_DOT },  // L
      {EL_NONE, EL_NONE, EL_NONE, EL_DASH, EL_DASH},  // M
      {EL_NONE, EL_NONE, EL_NONE, EL_DOT,  EL_DASH},  // N
      {EL_NONE, EL_NONE, EL_DASH, EL_DASH, EL_DASH},  // O
      {EL_NONE, EL_DOT,  EL_DASH, EL_DASH, EL_DOT },  // P
      {EL_NONE, EL_DASH, EL_DOT,  EL_DASH, EL_DASH},  // Q
      {EL_NONE, EL_NONE, EL_DOT,  EL_DASH, EL_DOT },  // R
      {EL_NONE, EL_NONE, EL_DOT,  EL_DOT,  EL_DOT },  // S
      {EL_NONE, EL_NONE, EL_NONE, EL_NONE, EL_DASH},  // T
      {EL_NONE, EL_NONE, EL_DASH, EL_DOT,  EL_DOT },  // U
      {EL_NONE, EL_DASH, EL_DOT,  EL_DOT,  EL_DOT },  // V
      {EL_NONE, EL_NONE, EL_DASH, EL_DASH, EL_DOT },  // W
      {EL_NONE, EL_DASH, EL_DOT,  EL_DOT,  EL_DASH},  // X
      {EL_NONE, EL_DASH, EL_DASH, EL_DOT,  EL_DASH},  // Y
      {EL_NONE, EL_DOT,  EL_DOT,  EL_DASH, EL_DASH},  // Z
      {EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DASH},  // 0
      {EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DOT },  // 1
      {EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_DOT },  // 2
      {EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_DOT },  // 3
      {EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT },  // 4
      {EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT },  // 5
      {EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH},  // 6
      {EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_DASH},  // 7
      {EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_DASH},  // 8
      {EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_DASH}   // 9
   };

   // Map a character to its table row; anything unknown keys as X
   function automatic logic [SymWidth-1:0] symbol_index(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] off;
      off = '0;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         off = c - CHAR_UC_A;
         return off[SymWidth-1:0];
      end
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         off = c - CHAR_LC_A;
         return off[SymWidth-1:0];
      end
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         off = c - CHAR_ZERO;
         return off[SymWidth-1:0] + SYM_DIGIT0;
      end
      return SYM_X;
   endfunction

endpackage

>>> hdl/morse_code_keyer.sv
// Top level of the Morse keyer: sequencer plus datapath.
//
//  Channel | Direction | Handshake          | Payload
//  req_    | in        | req_valid/stall    | character[7:0], end_of_message
//  rsp_    | out       | rsp_valid/stall    | key_on, units[2:0], last
//
// A character is taken in the wait step, then runs dispatch, an optional
// letter gap, two steps per element and a finish step; a space runs
// dispatch and then a space step that emits any pending word gap.
// Reset is synchronous and clears the step counter, the pending gap and the
// output valid. Each segment occupies the output register; a stalled output
// holds the sequencer on its emitting step.
module morse_code_keyer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [mck_pkg::CharWidth-1:0]  req_character,
   input  logic                           req_end_of_message,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_key_on,
   output logic [mck_pkg::UnitsWidth-1:0] rsp_units,
   output logic                           rsp_last
);
   import mck_pkg::*;

   ctrl_type  ctrl;
   flags_type flags;

   mck_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   mck_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_character      (req_character),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_on         (rsp_key_on),
      .rsp_units          (rsp_units),
      .rsp_last           (rsp_last),
      .ctrl               (ctrl),
      .flags              (flags)
   );

endmodule

>>> hdl/mck_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module mck_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mck_pkg::flags_type flags,
   output mck_pkg::ctrl_type  ctrl
);
   import mck_pkg::*;

   logic [StepWidth-1:0] step_ff;
   logic [StepWidth-1:0] step_in;
   ucode_type            word;
   logic                 cond_true;
   logic                 emit;
   logic                 go;

   // Control word fetch
   assign word = UCODE_ROM[step_ff];

   // Input side is open only while waiting
   assign req_stall = (step_ff != STEP_WAIT);

   // Branch condition decode
   always_comb begin
      unique case (word.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_IF_VALID: cond_true = req_valid;
         COND_IF_SPACE: cond_true = flags.is_space;
         COND_IF_MORE:  cond_true = flags.more;
         default:       cond_true = 1'b1;
      endcase
   end

   // An emitting step waits for room in the output register
   assign emit = (word.emit_sel == EMIT_ALWAYS) ||
                 ((word.emit_sel == EMIT_IF_GAP) && flags.gap);
   assign go   = !emit || flags.out_free;

   assign step_in = !go ? step_ff : (cond_true ? word.target : word.next);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.load = !req_stall && req_valid;
   assign ctrl.emit = emit;
   assign ctrl.go   = go;
   assign ctrl.word = word;

endmodule

>>> hdl/mck_datapath.sv
// Keyer datapath: character capture, element shifter, gap flag, output register.
module mck_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mck_pkg::CharWidth-1:0]    req_character,
   input  logic                             req_end_of_message,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_key_on,
   output logic [mck_pkg::UnitsWidth-1:0]   rsp_units,
   output logic                             rsp_last,
   input  mck_pkg::ctrl_type                ctrl,
   output mck_pkg::flags_type               flags
);
   import mck_pkg::*;

   logic                  space_ff,  space_in;
   logic                  eom_ff,    eom_in;
   logic [ElemsWidth-1:0] elems_ff,  elems_in;
   logic                  gap_ff,    gap_in;
   logic                  valid_ff,  valid_in;
   logic                  key_ff,    key_in;
   logic [UnitsWidth-1:0] units_ff,  units_in;
   logic                  last_ff,   last_in;
   logic                  more;
   logic [UnitsWidth-1:0] seg_units;
   logic                  seg_last;

   // Another element follows the current one
   assign more = (elems_ff[2*ElemWidth-1:ElemWidth] != EL_NONE);

   // Segment length select
   always_comb begin
      case (ctrl.word.units_sel)
         UNITS_WORD:   seg_units = WORD_GAP_UNITS;
         UNITS_LETTER: seg_units = LETTER_GAP_UNITS;
         UNITS_ELEM:   seg_units = {1'b0, elems_ff[ElemWidth-1:0]};
         default:      seg_units = ELEM_GAP_UNITS;
      endcase
   end

   // Last-segment select
   always_comb begin
      case (ctrl.word.last_sel)
         LAST_YES:     seg_last = 1'b1;
         LAST_NO_MORE: seg_last = !more;
         default:      seg_last = 1'b0;
      endcase
   end

   // Transaction capture and element shifting
   always_comb begin
      space_in = space_ff;
      eom_in   = eom_ff;
      elems_in = elems_ff;
      if (ctrl.load) begin
         space_in = (req_character == CHAR_SPACE);
         eom_in   = req_end_of_message;
         elems_in = MORSE_TAB[symbol_index(req_character)];
      end else if (ctrl.go && ctrl.word.elem_adv) begin
         elems_in = {{ElemWidth{1'b0}}, elems_ff[ElemsWidth-1:ElemWidth]};
      end
   end

   // Pending gap
   always_comb begin
      gap_in = gap_ff;
      if (ctrl.go) begin
         case (ctrl.word.gap_op)
            GAP_CLEAR:    gap_in = 1'b0;
            GAP_FROM_EOM: gap_in = !eom_ff;
            default:      gap_in = gap_ff;
         endcase
      end
   end

   // Output register
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      key_in   = key_ff;
      units_in = units_ff;
      last_in  = last_ff;
      if (ctrl.emit && ctrl.go) begin
         valid_in = 1'b1;
         key_in   = ctrl.word.key_on;
         units_in = seg_units;
         last_in  = seg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         gap_ff   <= gap_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      space_ff <= space_in;
      eom_ff   <= eom_in;
      elems_ff <= elems_in;
      key_ff   <= key_in;
      units_ff <= units_in;
      last_ff  <= last_in;
   end

   assign flags.is_space = space_ff;
   assign flags.more     = more;
   assign flags.gap      = gap_ff;
   assign flags.out_free = !valid_ff || !rsp_stall;

   assign rsp_valid  = valid_ff;
   assign rsp_key_on = key_ff;
   assign rsp_units  = units_ff;
   assign rsp_last   = last_ff;

endmodule

>>> hdl/mck_checker.sv
// Port-level checker for the Morse keyer, bound to the top level.
module mck_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_key_on,
   input logic [mck_pkg::UnitsWidth-1:0] rsp_units,
   input logic                           rsp_last
);
   import mck_pkg::*;

   // Stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_on) &&
      $stable(rsp_units) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // Only dot, dash, letter gap and word gap lengths exist
   a_units_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_units == ELEM_GAP_UNITS) || (rsp_units == LETTER_GAP_UNITS) ||
      (rsp_units == WORD_GAP_UNITS))
      else $error("illegal segment length");

   // A tone segment is never marked as the last of its transaction
   a_on_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_on |-> !rsp_last)
      else $error("tone segment marked last");

   // Word gap is key-up and ends its transaction
   a_word_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_units == WORD_GAP_UNITS) |-> !rsp_key_on && rsp_last)
      else $error("malformed word gap");

endmodule

bind morse_code_keyer mck_checker u_mck_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_key_on (rsp_key_on),
   .rsp_units  (rsp_units),
   .rsp_last   (rsp_last)
);
